@@ hdl/pfa_pkg.sv @@
package pfa_pkg;

    // Defaults for the top-level parameters
    localparam int FRAME_COUNT_DEF   = 64;
    localparam int PROCESS_SLOTS_DEF = 8;

    // Fixed field widths
    localparam int FS_W        = 7;
    localparam int FS_MAX      = 64;
    localparam int PID_W       = 16;
    localparam int SIZE_W      = 16;
    localparam int ADDR_W      = 31;
    localparam int PAGE_SHIFT  = 10;
    localparam int DIVN_W      = ADDR_W - PAGE_SHIFT;
    localparam int PAGES_W     = 7;
    localparam int PHYS_W      = 22;
    localparam int FREE_W      = 7;
    localparam int FREEKB_W    = 13;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 56;

    localparam logic [FS_W-1:0] FS_RESET = 7'd4;

    typedef enum logic [CMD_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_XLATE = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FEW      = 3'd1,
        ST_EXISTS   = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_RANGE    = 3'd4,
        ST_NOSLOT   = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_START,
        S_DIV,
        S_CHECK,
        S_ARD,
        S_AWR,
        S_DCHK,
        S_DRD,
        S_DWR,
        S_TRD,
        S_TMUL,
        S_TADD,
        S_FINISH
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic    init_wr;
        logic    latch_in;
        logic    div_start;
        logic    loop_clr;
        logic    alloc_wr;
        logic    alloc_commit;
        logic    free_wr;
        logic    free_commit;
        logic    tr_rd;
        logic    tr_mul;
        logic    tr_add;
        logic    set_status;
        status_t status;
        logic    load_out;
    } pfa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic init_last;
        logic div_done;
        op_t  op;
        logic need_too_many;
        logic need_zero;
        logic found;
        logic slot_avail;
        logic alloc_last;
        logic free_done;
        logic page_bad;
        logic out_free;
    } pfa_sts_t;

endpackage

@@ hdl/paged_frame_allocator.sv @@
// Paged frame allocator.
// Input stream: one beat per request. s_axis_tuser carries the command
// (allocate, deallocate, translate); s_axis_tdata carries process id, size
// in KB and logical byte address. Output stream: one beat per request with
// the status on m_axis_tuser and page count, physical address, free frames
// and free KB on m_axis_tdata. The cfg channel writes the frame size in KB.
// Requests are handled one at a time. Every request runs through a
// bit-serial divider (21 steps). Allocate then moves frames one at a time,
// each through the states S_ARD and S_AWR, and deallocate one at a time
// through S_DCHK, S_DRD and S_DWR, between the free queue and page table
// memories; translate adds a lookup, a multiply and an add. After reset
// the free queue is filled with frames 0 upward, one entry per cycle,
// before the first request is taken; the cfg channel is open throughout.
// A finished result sits in the output register until taken; the next
// request is taken in the meantime, and its result waits for the output
// register to drain.
module paged_frame_allocator #(
    parameter int FRAME_COUNT   = pfa_pkg::FRAME_COUNT_DEF,
    parameter int PROCESS_SLOTS = pfa_pkg::PROCESS_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // process_id[15:0], memory_size_kb[31:16], logical_address[62:32]
    input  logic [pfa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // command[1:0]
    input  logic [pfa_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // page_count[6:0], physical_address[28:7], free_frames[35:29],
    // free_memory_kb[48:36]
    output logic [pfa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [pfa_pkg::STATUS_W-1:0]    m_axis_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    // frame_size_kb
    input  logic [pfa_pkg::FS_W-1:0]        cfg_data
);

    import pfa_pkg::*;

    pfa_cmd_t cmd;
    pfa_sts_t sts;

    assign cfg_ready = 1'b1;

    pfa_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    pfa_datapath #(
        .FRAME_COUNT   (FRAME_COUNT),
        .PROCESS_SLOTS (PROCESS_SLOTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

@@ hdl/pfa_ram.sv @@
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/pfa_div.sv @@
module pfa_div #(
    parameter int NW = 21,
    parameter int DW = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient,
    output logic [DW-1:0] remainder
);

    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    dvs_reg;

    logic [DW:0]      trial;
    logic             ge;
    logic [DW:0]      diff;

    // One restoring step: shift in the next dividend bit and try a subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[NW-1]};
        ge    = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ hdl/pfa_ctrl.sv @@
module pfa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  pfa_pkg::pfa_sts_t sts,
    output pfa_pkg::pfa_cmd_t cmd
);

    import pfa_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.status    = ST_OK;
        s_axis_tready = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                // fill the free queue with 0, 1, 2, ...
                cmd.init_wr = 1'b1;
                if (sts.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_START;
                end
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.loop_clr = 1'b1;
                state_next   = S_FINISH;
                case (sts.op)
                    OP_ALLOC:
                    begin
                        if (sts.need_too_many)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_FEW;
                        end
                        else if (sts.found)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_EXISTS;
                        end
                        else if (!sts.slot_avail)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_NOSLOT;
                        end
                        else if (sts.need_zero)
                        begin
                            cmd.alloc_commit = 1'b1;
                        end
                        else
                        begin
                            state_next = S_ARD;
                        end
                    end
                    OP_FREE:
                    begin
                        if (!sts.found)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_NOTFOUND;
                        end
                        else
                        begin
                            state_next = S_DCHK;
                        end
                    end
                    OP_XLATE:
                    begin
                        if (!sts.found)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_NOTFOUND;
                        end
                        else if (sts.page_bad)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_RANGE;
                        end
                        else
                        begin
                            state_next = S_TRD;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            // allocate: read queue head, then write it into the page table
            S_ARD:
            begin
                state_next = S_AWR;
            end
            S_AWR:
            begin
                cmd.alloc_wr = 1'b1;
                if (sts.alloc_last)
                begin
                    cmd.alloc_commit = 1'b1;
                    state_next       = S_FINISH;
                end
                else
                begin
                    state_next = S_ARD;
                end
            end
            // free: read a page table entry, then push it at the queue tail
            S_DCHK:
            begin
                if (sts.free_done)
                begin
                    cmd.free_commit = 1'b1;
                    state_next      = S_FINISH;
                end
                else
                begin
                    state_next = S_DRD;
                end
            end
            S_DRD:
            begin
                state_next = S_DWR;
            end
            S_DWR:
            begin
                cmd.free_wr = 1'b1;
                state_next  = S_DCHK;
            end
            // translate: frame lookup, multiply, add offset
            S_TRD:
            begin
                cmd.tr_rd  = 1'b1;
                state_next = S_TMUL;
            end
            S_TMUL:
            begin
                cmd.tr_mul = 1'b1;
                state_next = S_TADD;
            end
            S_TADD:
            begin
                cmd.tr_add = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/pfa_datapath.sv @@
module pfa_datapath #(
    parameter int FRAME_COUNT   = pfa_pkg::FRAME_COUNT_DEF,
    parameter int PROCESS_SLOTS = pfa_pkg::PROCESS_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [pfa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [pfa_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [pfa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [pfa_pkg::STATUS_W-1:0]    m_axis_tuser,
    input  logic                            cfg_valid,
    input  logic [pfa_pkg::FS_W-1:0]        cfg_data,
    input  pfa_pkg::pfa_cmd_t               cmd,
    output pfa_pkg::pfa_sts_t               sts
);

    import pfa_pkg::*;

    localparam int FW   = $clog2(FRAME_COUNT);
    localparam int CW   = $clog2(FRAME_COUNT + 1);
    localparam int SW   = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
    localparam int PT_D = 2 ** (SW + FW);
    localparam int MW   = FW + FS_W;
    localparam int KW   = CW + FS_W;

    // Configuration and control state
    logic [FS_W-1:0]   fs_reg;
    logic [FW-1:0]     head_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     idx_reg;
    logic [PROCESS_SLOTS-1:0] slot_valid_reg;
    logic              out_valid_reg;

    // Payload registers
    logic [PID_W-1:0]  slot_pid_reg   [PROCESS_SLOTS];
    logic [CW-1:0]     slot_pages_reg [PROCESS_SLOTS];
    op_t               op_reg;
    logic [PID_W-1:0]  pid_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] addr_reg;
    status_t           res_status_reg;
    logic [CW-1:0]     res_pages_reg;
    logic [PHYS_W-1:0] res_phys_reg;
    logic [MW-1:0]     mul_reg;
    status_t           out_status_reg;
    logic [PAGES_W-1:0]  out_pages_reg;
    logic [PHYS_W-1:0]   out_phys_reg;
    logic [FREE_W-1:0]   out_free_reg;
    logic [FREEKB_W-1:0] out_kb_reg;

    logic [FS_W-1:0]   fs_eff;
    logic [DIVN_W-1:0] dividend;
    logic              div_done;
    logic [DIVN_W-1:0] quo;
    logic [FS_W-1:0]   rem;
    logic              found;
    logic [SW-1:0]     found_idx;
    logic              slot_avail;
    logic [SW-1:0]     free_idx;
    logic [FW-1:0]     head_inc;
    logic [CW:0]       tail_sum;
    logic [FW-1:0]     tail;
    logic [CW-1:0]     found_pages;

    logic              fq_we;
    logic [FW-1:0]     fq_waddr;
    logic [FW-1:0]     fq_wdata;
    logic [FW-1:0]     fq_rdata;
    logic              pt_we;
    logic [SW+FW-1:0]  pt_waddr;
    logic [SW+FW-1:0]  pt_raddr;
    logic [FW-1:0]     pt_rdata;

    logic [MW:0]       xl_sum;
    logic [31:0]       xl_full;
    logic [KW-1:0]     kb_prod;
    logic [31:0]       kb_wide;
    logic [31:0]       pages_wide;
    logic [31:0]       free_wide;

    // Frame size clamped to 1..64
    always_comb
    begin
        if (fs_reg == '0)
        begin
            fs_eff = FS_W'(1);
        end
        else if (fs_reg > FS_W'(FS_MAX))
        begin
            fs_eff = FS_W'(FS_MAX);
        end
        else
        begin
            fs_eff = fs_reg;
        end
    end

    // Divider operand: size + frame size - 1 for allocate (quotient is the page count), address in KB otherwise
    always_comb
    begin
        if (op_reg == OP_ALLOC)
        begin
            dividend = DIVN_W'((SIZE_W + 1)'(size_reg) + (SIZE_W + 1)'(fs_eff)
                               - (SIZE_W + 1)'(1));
        end
        else
        begin
            dividend = addr_reg[ADDR_W-1:PAGE_SHIFT];
        end
    end

    pfa_div #(
        .NW (DIVN_W),
        .DW (FS_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dividend),
        .divisor   (fs_eff),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    // Slot search: lowest matching and lowest free slot
    always_comb
    begin
        found      = 1'b0;
        found_idx  = '0;
        slot_avail = 1'b0;
        free_idx   = '0;
        for (int s = PROCESS_SLOTS - 1; s >= 0; s--)
        begin
            if (slot_valid_reg[s] && slot_pid_reg[s] == pid_reg)
            begin
                found     = 1'b1;
                found_idx = SW'(s);
            end
            if (!slot_valid_reg[s])
            begin
                slot_avail = 1'b1;
                free_idx   = SW'(s);
            end
        end
        found_pages = slot_pages_reg[found_idx];
    end

    // Queue pointers
    always_comb
    begin
        head_inc = (head_reg == FW'(FRAME_COUNT - 1)) ? '0 : head_reg + 1'b1;
        tail_sum = (CW + 1)'(head_reg) + (CW + 1)'(count_reg);
        if (tail_sum >= (CW + 1)'(FRAME_COUNT))
        begin
            tail_sum = tail_sum - (CW + 1)'(FRAME_COUNT);
        end
        tail = tail_sum[FW-1:0];
    end

    // Memory ports
    always_comb
    begin
        fq_we    = cmd.init_wr || cmd.free_wr;
        fq_waddr = cmd.init_wr ? idx_reg[FW-1:0] : tail;
        fq_wdata = cmd.init_wr ? idx_reg[FW-1:0] : pt_rdata;
        pt_we    = cmd.alloc_wr;
        pt_waddr = {free_idx, idx_reg[FW-1:0]};
        pt_raddr = cmd.tr_rd ? {found_idx, quo[FW-1:0]} : {found_idx, idx_reg[FW-1:0]};
    end

    pfa_ram #(
        .WIDTH (FW),
        .DEPTH (FRAME_COUNT)
    ) u_free_queue (
        .clk     (clk),
        .wr_en   (fq_we),
        .wr_addr (fq_waddr),
        .wr_data (fq_wdata),
        .rd_addr (head_reg),
        .rd_data (fq_rdata)
    );

    pfa_ram #(
        .WIDTH (FW),
        .DEPTH (PT_D)
    ) u_page_table (
        .clk     (clk),
        .wr_en   (pt_we),
        .wr_addr (pt_waddr),
        .wr_data (fq_rdata),
        .rd_addr (pt_raddr),
        .rd_data (pt_rdata)
    );

    // Translate sum and output packing helpers
    always_comb
    begin
        xl_sum     = (MW + 1)'(mul_reg) + (MW + 1)'(rem);
        xl_full    = 32'({xl_sum, addr_reg[PAGE_SHIFT-1:0]});
        kb_prod    = KW'(count_reg) * KW'(fs_eff);
        kb_wide    = 32'(kb_prod);
        pages_wide = 32'(res_pages_reg);
        free_wide  = 32'(count_reg);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg         <= FS_RESET;
            head_reg       <= '0;
            count_reg      <= CW'(FRAME_COUNT);
            idx_reg        <= '0;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                fs_reg <= cfg_data;
            end
            if (cmd.init_wr || cmd.alloc_wr || cmd.free_wr)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            else if (cmd.loop_clr)
            begin
                idx_reg <= '0;
            end
            if (cmd.alloc_wr)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.free_wr)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.alloc_commit)
            begin
                slot_valid_reg[free_idx] <= 1'b1;
            end
            if (cmd.free_commit)
            begin
                slot_valid_reg[found_idx] <= 1'b0;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg         <= op_t'(s_axis_tuser);
            pid_reg        <= s_axis_tdata[PID_W-1:0];
            size_reg       <= s_axis_tdata[PID_W +: SIZE_W];
            addr_reg       <= s_axis_tdata[PID_W + SIZE_W +: ADDR_W];
            res_status_reg <= ST_OK;
            res_pages_reg  <= '0;
            res_phys_reg   <= '0;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status;
        end
        if (cmd.alloc_commit)
        begin
            slot_pid_reg[free_idx]   <= pid_reg;
            slot_pages_reg[free_idx] <= quo[CW-1:0];
            res_pages_reg            <= quo[CW-1:0];
        end
        if (cmd.free_commit)
        begin
            res_pages_reg <= found_pages;
        end
        if (cmd.tr_mul)
        begin
            mul_reg <= MW'(pt_rdata) * MW'(fs_eff);
        end
        if (cmd.tr_add)
        begin
            res_phys_reg <= xl_full[PHYS_W-1:0];
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_pages_reg  <= pages_wide[PAGES_W-1:0];
            out_phys_reg   <= res_phys_reg;
            out_free_reg   <= free_wide[FREE_W-1:0];
            out_kb_reg     <= kb_wide[FREEKB_W-1:0];
        end
    end

    // Status to the controller
    always_comb
    begin
        sts               = '0;
        sts.init_last     = idx_reg == CW'(FRAME_COUNT - 1);
        sts.div_done      = div_done;
        sts.op            = op_reg;
        sts.need_too_many = quo > DIVN_W'(count_reg);
        sts.need_zero     = quo == '0;
        sts.found         = found;
        sts.slot_avail    = slot_avail;
        sts.alloc_last    = DIVN_W'(idx_reg) + DIVN_W'(1) == quo;
        sts.free_done     = (idx_reg == found_pages) || (count_reg == CW'(FRAME_COUNT));
        sts.page_bad      = (quo >= DIVN_W'(found_pages)) || (quo >= DIVN_W'(FRAME_COUNT));
        sts.out_free      = !out_valid_reg || m_axis_tready;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {7'd0, out_kb_reg, out_free_reg, out_phys_reg, out_pages_reg};

endmodule

@@ bench/paged_frame_allocator_tb.sv @@
`timescale 1ns / 1ps

// Expected response of one request
typedef struct {
    pfa_pkg::status_t status;
    logic [6:0]       pages;
    logic [21:0]      phys;
    logic [6:0]       free_frames;
    logic [12:0]      free_kb;
} pfa_resp_t;

// Mirror of the allocator: free queue, slots and page tables
class pfa_scoreboard;
    int unsigned free_queue[64];
    int unsigned q_head;
    int unsigned q_count;
    bit          slot_used[8];
    int unsigned slot_owner[8];
    int unsigned slot_len[8];
    int unsigned page_map[8][64];
    int unsigned frame_kb;
    pfa_resp_t   resp_q[$];
    int          mismatches;
    int          responses;

    function new();
        for (int i = 0; i < 64; i++)
            free_queue[i] = i;
        q_head = 0;
        q_count = 64;
        foreach (slot_used[s])
            slot_used[s] = 0;
        frame_kb = 4;
        mismatches = 0;
        responses = 0;
    endfunction

    function void set_frame_kb(logic [6:0] v);
        frame_kb = 32'(v);
    endfunction

    function int unsigned eff_kb();
        if (frame_kb == 0)
            return 1;
        if (frame_kb > 64)
            return 64;
        return frame_kb;
    endfunction

    function int lookup(int unsigned pid);
        for (int s = 0; s < 8; s++)
            if (slot_used[s] && slot_owner[s] == pid)
                return s;
        return -1;
    endfunction

    // Accepted request beat: work out its response
    function void note_request(pfa_pkg::op_t op, int unsigned pid, int unsigned size,
                               int unsigned addr);
        pfa_resp_t   r;
        int unsigned fs, need, pbytes, page;
        int          s;
        fs = eff_kb();
        r.status = pfa_pkg::ST_OK;
        r.pages = 0;
        r.phys = 0;
        case (op)
            pfa_pkg::OP_ALLOC:
            begin
                need = (size + fs - 1) / fs;
                s = -1;
                for (int k = 0; k < 8; k++)
                    if (s < 0 && !slot_used[k])
                        s = k;
                if (need > q_count)
                    r.status = pfa_pkg::ST_FEW;
                else if (lookup(pid) >= 0)
                    r.status = pfa_pkg::ST_EXISTS;
                else if (s < 0)
                    r.status = pfa_pkg::ST_NOSLOT;
                else
                begin
                    for (int i = 0; i < need; i++)
                    begin
                        page_map[s][i] = free_queue[q_head];
                        q_head = (q_head + 1) % 64;
                        q_count--;
                    end
                    slot_used[s] = 1;
                    slot_owner[s] = pid;
                    slot_len[s] = need;
                    r.pages = 7'(need);
                end
            end
            pfa_pkg::OP_FREE:
            begin
                s = lookup(pid);
                if (s < 0)
                    r.status = pfa_pkg::ST_NOTFOUND;
                else
                begin
                    for (int i = 0; i < slot_len[s] && q_count < 64; i++)
                    begin
                        free_queue[(q_head + q_count) % 64] = page_map[s][i];
                        q_count++;
                    end
                    slot_used[s] = 0;
                    r.pages = 7'(slot_len[s]);
                end
            end
            pfa_pkg::OP_XLATE:
            begin
                s = lookup(pid);
                if (s < 0)
                    r.status = pfa_pkg::ST_NOTFOUND;
                else
                begin
                    pbytes = fs * 1024;
                    page = addr / pbytes;
                    if (page >= slot_len[s] || page >= 64)
                        r.status = pfa_pkg::ST_RANGE;
                    else
                        r.phys = 22'(page_map[s][page] * pbytes + addr % pbytes);
                end
            end
            default: ;
        endcase
        r.free_frames = 7'(q_count);
        r.free_kb = 13'(q_count * fs);
        resp_q = {resp_q, r};
    endfunction

    // Accepted response beat: compare with the oldest expectation
    function void check_result(logic [2:0] status, logic [55:0] data);
        pfa_resp_t e;
        bit        bad;
        responses++;
        if (resp_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected response beat, status %0d data %h", status, data);
            return;
        end
        e = resp_q.pop_front();
        bad = (status !== e.status) || (data[6:0] !== e.pages) ||
              (data[28:7] !== e.phys) || (data[35:29] !== e.free_frames) ||
              (data[48:36] !== e.free_kb);
        if (bad)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"ERROR: beat %0d exp st=%0d pg=%0d pa=%h ff=%0d kb=%0d, ",
                          "got st=%0d pg=%0d pa=%h ff=%0d kb=%0d"},
                         responses, e.status, e.pages, e.phys, e.free_frames, e.free_kb,
                         status, data[6:0], data[28:7], data[35:29], data[48:36]);
        end
    endfunction
endclass

module paged_frame_allocator_tb;
    import pfa_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [CMD_W-1:0]       s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [FS_W-1:0]        cfg_data;

    pfa_scoreboard sb;
    bit            steady;      // no idling on either side
    bit            rx_hold;     // receiver held off
    int unsigned   cycles;
    int unsigned   req_count;
    int unsigned   cur_kb;

    paged_frame_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver: random backpressure, or held off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !rx_hold && (steady || $urandom_range(99) >= 34);
    end

    // Beat monitors
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            sb.note_request(op_t'(s_axis_tuser), 32'(s_axis_tdata[15:0]),
                            32'(s_axis_tdata[31:16]), 32'(s_axis_tdata[62:32]));
            req_count++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_request(op_t op, logic [15:0] pid, logic [15:0] size,
                                logic [30:0] addr);
        while (!steady && $urandom_range(99) < 34)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {1'b0, addr, size, pid};
        forever
        begin
            @(negedge clk);
            if (s_axis_tready)
                break;
        end
        @(posedge clk);
    endtask

    // Drain, then write the frame size while idle
    task automatic write_frame_kb(logic [6:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.resp_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        forever
        begin
            @(negedge clk);
            if (cfg_ready)
                break;
        end
        @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_frame_kb(v);
        cur_kb = sb.eff_kb();
    endtask

    task automatic random_request();
        op_t         op;
        logic [15:0] pid, size;
        logic [30:0] addr;
        int unsigned r;
        r = $urandom_range(99);
        op = r < 35 ? OP_ALLOC : r < 58 ? OP_FREE : r < 95 ? OP_XLATE : OP_NOP;
        r = $urandom_range(99);
        pid = 16'(r < 90 ? $urandom_range(11) : r < 95 ? 32'hFFFF : $urandom);
        size = 16'($urandom_range(99) < 88 ? $urandom_range(cur_kb * 8) : $urandom);
        if ($urandom_range(99) < 75)
            addr = 31'($urandom_range(9) * cur_kb * 1024
                       + $urandom_range(cur_kb * 1024 - 1));
        else
            addr = 31'($urandom);
        send_request(op, pid, size, addr);
    endtask

    // Pressure: long receiver hold-off while requests keep coming
    initial
    begin
        rx_hold = 1'b0;
        wait (req_count >= 900);
        rx_hold = 1'b1;
        repeat (600) @(posedge clk);
        rx_hold = 1'b0;
    end

    initial
    begin
        logic [6:0] kb_plan[8];
        kb_plan = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd7, 7'd16, 7'd3, 7'd4};
        sb = new();
        cycles = 0;
        req_count = 0;
        cur_kb = 4;
        steady = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_NOP;
        cfg_valid = 1'b0;
        cfg_data = FS_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero size, full memory, each error, extremes
        send_request(OP_ALLOC, 16'h0000, 16'h0000, '0);
        send_request(OP_XLATE, 16'h0000, 16'h0000, '0);
        send_request(OP_ALLOC, 16'hFFFF, 16'hFFFF, '1);
        send_request(OP_ALLOC, 16'h0001, 16'd256, '0);
        send_request(OP_ALLOC, 16'h0002, 16'd1, '0);
        send_request(OP_XLATE, 16'h0001, 16'h0000, 31'h7FFF_FFFF);
        send_request(OP_XLATE, 16'h0001, 16'hFFFF, 31'd262143);
        send_request(OP_XLATE, 16'h0009, 16'h0000, 31'd5);
        send_request(OP_FREE, 16'h0001, 16'h0000, '0);
        send_request(OP_FREE, 16'h0001, 16'h0000, '0);
        send_request(OP_ALLOC, 16'h0000, 16'd3, '0);
        for (int p = 2; p <= 9; p++)
            send_request(OP_ALLOC, p[15:0], 16'd5, '0);
        send_request(OP_NOP, 16'hFFFF, 16'hFFFF, '1);
        send_request(OP_FREE, 16'h0000, 16'h0000, '0);
        for (int p = 2; p <= 8; p++)
            send_request(OP_FREE, p[15:0], 16'h0000, '0);

        // Random phases over frame sizes, one phase without idling
        foreach (kb_plan[i])
        begin
            write_frame_kb(kb_plan[i]);
            steady = (i == 4);
            repeat (228) random_request();
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (sb.resp_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("%0d requests checked over %0d frame sizes incl. out-of-range values,",
                 req_count, 8);
        $display("with a long output stall, %0d cycles", cycles);
        if (sb.mismatches == 0 && sb.resp_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d mismatches", sb.mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

@@ files.f @@
hdl/pfa_pkg.sv
hdl/pfa_ram.sv
hdl/pfa_div.sv
hdl/pfa_ctrl.sv
hdl/pfa_datapath.sv
hdl/paged_frame_allocator.sv
bench/paged_frame_allocator_tb.sv
